>>> hw/rtl/set_min_max_mean_reducer_defines.svh
// Assertion macros shared by the checker.
`ifndef SET_MIN_MAX_MEAN_REDUCER_DEFINES_SVH
`define SET_MIN_MAX_MEAN_REDUCER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SMMM_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SMMM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/smmm_pkg.sv
`timescale 1ns / 1ps

package smmm_pkg;

  localparam int MASK_W  = 32;
  localparam int LEVEL_W = 32;
  localparam int COUNT_W = 32;
  localparam int SUM_W   = 64;

  // One quotient bit per step over the whole sum.
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic acc_en;    // fold the accepted beat into the accumulators
    logic div_load;  // copy sums into the dividers
    logic div_step;  // one restoring-division step
    logic out_load;  // capture result and close the open set
  } smmm_cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or being drained this cycle
  } smmm_sts_t;

endpackage

>>> hw/rtl/set_min_max_mean_reducer.sv
`timescale 1ns / 1ps
// Set reducer: folds a stream of records into one summary beat per set.
// Input channel (in_*): one record per beat, in_last_item marks the record
// that closes a set. Within a set a beat is taken every cycle.
// Output channel (out_*): one beat per set with the record count, AND and OR
// of the masks, and min, max and truncated mean of both levels.
// After the closing beat is taken, the block loads two 64-step restoring
// dividers that run side by side, one quotient bit a cycle, then fills the
// output register once that register is free.
// in_stall stays high after the closing beat is taken until the result is
// loaded into the output register.
// If the receiver stalls, the result holds in the output register; the next
// set is accepted meanwhile and waits after its division until the register
// drains. The count and the sums saturate; a mean that no longer fits a
// level reads as all ones.
// Reset (rst_n low, synchronous) closes any open set, drops a pending
// result and leaves the block ready for the first record.

module set_min_max_mean_reducer
  import smmm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MASK_W-1:0]   in_mask_bits,
  input  logic [LEVEL_W-1:0]  in_level_a,
  input  logic [LEVEL_W-1:0]  in_level_b,
  input  logic                in_last_item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COUNT_W-1:0]  out_item_total,
  output logic [MASK_W-1:0]   out_mask_all,
  output logic [MASK_W-1:0]   out_mask_any,
  output logic [LEVEL_W-1:0]  out_a_min,
  output logic [LEVEL_W-1:0]  out_a_max,
  output logic [LEVEL_W-1:0]  out_a_mean,
  output logic [LEVEL_W-1:0]  out_b_min,
  output logic [LEVEL_W-1:0]  out_b_max,
  output logic [LEVEL_W-1:0]  out_b_mean
);

  smmm_cmd_t cmd;
  smmm_sts_t sts;

  smmm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .sts          (sts),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  smmm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mask_bits   (in_mask_bits),
    .in_level_a     (in_level_a),
    .in_level_b     (in_level_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item_total (out_item_total),
    .out_mask_all   (out_mask_all),
    .out_mask_any   (out_mask_any),
    .out_a_min      (out_a_min),
    .out_a_max      (out_a_max),
    .out_a_mean     (out_a_mean),
    .out_b_min      (out_b_min),
    .out_b_max      (out_b_max),
    .out_b_mean     (out_b_mean)
  );

endmodule

>>> hw/rtl/smmm_ctrl.sv
`timescale 1ns / 1ps

module smmm_ctrl
  import smmm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last_item,
  input  smmm_sts_t sts,
  output logic      in_stall,
  output smmm_cmd_t cmd
);

  localparam logic [1:0] S_ACC  = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_ACC: begin
        in_stall   = 1'b0;
        cmd.acc_en = in_valid;
        if (in_valid && in_last_item) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold the finished set until the output register can take it
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

>>> hw/rtl/smmm_dp.sv
`timescale 1ns / 1ps

module smmm_dp
  import smmm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  smmm_cmd_t           cmd,
  output smmm_sts_t           sts,
  input  logic [MASK_W-1:0]   in_mask_bits,
  input  logic [LEVEL_W-1:0]  in_level_a,
  input  logic [LEVEL_W-1:0]  in_level_b,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COUNT_W-1:0]  out_item_total,
  output logic [MASK_W-1:0]   out_mask_all,
  output logic [MASK_W-1:0]   out_mask_any,
  output logic [LEVEL_W-1:0]  out_a_min,
  output logic [LEVEL_W-1:0]  out_a_max,
  output logic [LEVEL_W-1:0]  out_a_mean,
  output logic [LEVEL_W-1:0]  out_b_min,
  output logic [LEVEL_W-1:0]  out_b_max,
  output logic [LEVEL_W-1:0]  out_b_mean
);

  // accumulators
  logic               in_set_r;
  logic [COUNT_W-1:0] count_r;
  logic [MASK_W-1:0]  and_r, or_r;
  logic [LEVEL_W-1:0] a_low_r, a_high_r, b_low_r, b_high_r;
  logic [SUM_W-1:0]   a_tot_r, b_tot_r;

  logic [SUM_W:0]     a_sum, b_sum;
  logic [COUNT_W-1:0] count_inc;

  // restoring dividers: dividend shifts out as the quotient shifts in
  logic [COUNT_W-1:0] a_rem_r, b_rem_r;
  logic [SUM_W-1:0]   a_dq_r, b_dq_r;
  logic [COUNT_W:0]   a_trial, b_trial;
  logic [LEVEL_W-1:0] a_mean, b_mean;

  // output register
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_item_total_r;
  logic [MASK_W-1:0]  out_mask_all_r, out_mask_any_r;
  logic [LEVEL_W-1:0] out_a_min_r, out_a_max_r, out_a_mean_r;
  logic [LEVEL_W-1:0] out_b_min_r, out_b_max_r, out_b_mean_r;

  assign a_sum     = {1'b0, a_tot_r} + {{(SUM_W - LEVEL_W + 1){1'b0}}, in_level_a};
  assign b_sum     = {1'b0, b_tot_r} + {{(SUM_W - LEVEL_W + 1){1'b0}}, in_level_b};
  assign count_inc = (&count_r) ? count_r : count_r + 1'b1;

  assign a_trial = {a_rem_r, a_dq_r[SUM_W-1]} - {1'b0, count_r};
  assign b_trial = {b_rem_r, b_dq_r[SUM_W-1]} - {1'b0, count_r};

  // clip quotients that do not fit a level
  assign a_mean = (|a_dq_r[SUM_W-1:LEVEL_W]) ? '1 : a_dq_r[LEVEL_W-1:0];
  assign b_mean = (|b_dq_r[SUM_W-1:LEVEL_W]) ? '1 : b_dq_r[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_set_r <= 1'b0;
    end else if (cmd.out_load) begin
      in_set_r <= 1'b0;
    end else if (cmd.acc_en) begin
      in_set_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      if (!in_set_r) begin
        count_r  <= COUNT_W'(1);
        and_r    <= in_mask_bits;
        or_r     <= in_mask_bits;
        a_low_r  <= in_level_a;
        a_high_r <= in_level_a;
        b_low_r  <= in_level_b;
        b_high_r <= in_level_b;
        a_tot_r  <= SUM_W'(in_level_a);
        b_tot_r  <= SUM_W'(in_level_b);
      end else begin
        count_r  <= count_inc;
        and_r    <= and_r & in_mask_bits;
        or_r     <= or_r | in_mask_bits;
        a_low_r  <= (in_level_a < a_low_r)  ? in_level_a : a_low_r;
        a_high_r <= (in_level_a > a_high_r) ? in_level_a : a_high_r;
        b_low_r  <= (in_level_b < b_low_r)  ? in_level_b : b_low_r;
        b_high_r <= (in_level_b > b_high_r) ? in_level_b : b_high_r;
        a_tot_r  <= a_sum[SUM_W] ? '1 : a_sum[SUM_W-1:0];
        b_tot_r  <= b_sum[SUM_W] ? '1 : b_sum[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      a_rem_r <= '0;
      b_rem_r <= '0;
      a_dq_r  <= a_tot_r;
      b_dq_r  <= b_tot_r;
    end else if (cmd.div_step) begin
      if (!a_trial[COUNT_W]) begin
        a_rem_r <= a_trial[COUNT_W-1:0];
      end else begin
        a_rem_r <= {a_rem_r[COUNT_W-2:0], a_dq_r[SUM_W-1]};
      end
      a_dq_r <= {a_dq_r[SUM_W-2:0], ~a_trial[COUNT_W]};
      if (!b_trial[COUNT_W]) begin
        b_rem_r <= b_trial[COUNT_W-1:0];
      end else begin
        b_rem_r <= {b_rem_r[COUNT_W-2:0], b_dq_r[SUM_W-1]};
      end
      b_dq_r <= {b_dq_r[SUM_W-2:0], ~b_trial[COUNT_W]};
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_total_r <= count_r;
      out_mask_all_r   <= and_r;
      out_mask_any_r   <= or_r;
      out_a_min_r      <= a_low_r;
      out_a_max_r      <= a_high_r;
      out_a_mean_r     <= a_mean;
      out_b_min_r      <= b_low_r;
      out_b_max_r      <= b_high_r;
      out_b_mean_r     <= b_mean;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_item_total = out_item_total_r;
  assign out_mask_all   = out_mask_all_r;
  assign out_mask_any   = out_mask_any_r;
  assign out_a_min      = out_a_min_r;
  assign out_a_max      = out_a_max_r;
  assign out_a_mean     = out_a_mean_r;
  assign out_b_min      = out_b_min_r;
  assign out_b_max      = out_b_max_r;
  assign out_b_mean     = out_b_mean_r;

endmodule

>>> hw/rtl/smmm_chk.sv
`timescale 1ns / 1ps
`include "set_min_max_mean_reducer_defines.svh"

module smmm_chk
  import smmm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_last_item,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COUNT_W-1:0] out_item_total,
  input logic [MASK_W-1:0]  out_mask_all,
  input logic [MASK_W-1:0]  out_mask_any,
  input logic [LEVEL_W-1:0] out_a_min,
  input logic [LEVEL_W-1:0] out_a_max,
  input logic [LEVEL_W-1:0] out_a_mean,
  input logic [LEVEL_W-1:0] out_b_min,
  input logic [LEVEL_W-1:0] out_b_max,
  input logic [LEVEL_W-1:0] out_b_mean
);

  // a stalled result beat holds
  `SMMM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_a_mean) && $stable(out_b_mean) && $stable(out_item_total), "stalled result beat changed")

  // closing a set starts the division, so input stalls next cycle
  `SMMM_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && in_last_item, in_stall, "input not held after closing beat")

  // a fresh result only follows a division, during which input was held
  `SMMM_ASSERT_NOW(a_new_result, $rose(out_valid), $past(in_stall), "result without preceding division")

  // summary is self-consistent
  `SMMM_ASSERT_NOW(a_summary, out_valid, (out_item_total != '0) && (out_a_min <= out_a_max) && (out_b_min <= out_b_max) && ((out_mask_all & ~out_mask_any) == '0), "inconsistent summary beat")

endmodule

bind set_min_max_mean_reducer smmm_chk u_smmm_chk (.*);
